// ----- sv/lrad_pkg.sv -----
// ----------------------------------------------------------------------------
// lrad_pkg
// shared types and constants of the downlink resource allocation decoder
// ----------------------------------------------------------------------------
package lrad_pkg;

	localparam int unsigned NRB        = 25;
	localparam int unsigned FIELD_W    = 13;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned T0_PAIRS   = 12;
	localparam int unsigned T1_BITS    = 11;
	localparam int unsigned RIV_MAX    = 324;
	localparam int unsigned RECIP_MUL  = 41;
	localparam int unsigned RECIP_SHR  = 10;

	typedef enum logic [1:0] {
		MODE_T0   = 2'd0,
		MODE_T1   = 2'd1,
		MODE_LOC  = 2'd2,
		MODE_DIST = 2'd3
	} mode_t;

	typedef struct packed {
		logic [CNT_W-1:0] start;
		logic [CNT_W-1:0] len;
		logic             is_dist;
	} span_t;

	// (6p) mod 23, zero mapped to 23
	localparam logic [CNT_W-1:0] DIST_POS [NRB] = '{
		5'd23, 5'd6,  5'd12, 5'd18, 5'd1,  5'd7,  5'd13, 5'd19, 5'd2,  5'd8,
		5'd14, 5'd20, 5'd3,  5'd9,  5'd15, 5'd21, 5'd4,  5'd10, 5'd16, 5'd22,
		5'd5,  5'd11, 5'd17, 5'd23, 5'd6
	};

endpackage

// ----- sv/lrad_riv_split.sv -----
// ----------------------------------------------------------------------------
// lrad_riv_split
// splits a resource indication value into quotient and remainder by 25
// ----------------------------------------------------------------------------
module lrad_riv_split (
	input  logic [lrad_pkg::FIELD_W-1:0] alloc_field,
	output logic [3:0]                   quo,
	output logic [4:0]                   rem,
	output logic                         riv_ok
);

	logic [8:0]  f9;
	logic [14:0] prod;
	logic [4:0]  quo5;
	logic [8:0]  rem9;

	always_comb begin
		f9     = alloc_field[8:0];
		prod   = 15'(f9) * 15'(lrad_pkg::RECIP_MUL);
		quo5   = prod[14:lrad_pkg::RECIP_SHR];
		rem9   = f9 - 9'(quo5) * 9'(lrad_pkg::NRB);
		quo    = quo5[3:0];
		rem    = rem9[4:0];
		riv_ok = (alloc_field <= lrad_pkg::FIELD_W'(lrad_pkg::RIV_MAX));
	end

endmodule

// ----- sv/lrad_span_map.sv -----
// ----------------------------------------------------------------------------
// lrad_span_map
// expands a start and length into a localized or distributed block map
// ----------------------------------------------------------------------------
module lrad_span_map (
	input  lrad_pkg::span_t          span,
	output logic [lrad_pkg::NRB-1:0] map
);

	logic [5:0]                end_pos;
	logic [lrad_pkg::NRB-1:0]  in_span;
	logic [lrad_pkg::NRB-1:0]  dist_map;

	always_comb begin
		end_pos  = 6'(span.start) + 6'(span.len);
		dist_map = '0;
		for (int p = 0; p < lrad_pkg::NRB; p++) begin
			in_span[p] = (6'(p) >= 6'(span.start)) && (6'(p) < end_pos);
			if (in_span[p]) begin
				dist_map[lrad_pkg::DIST_POS[p]] = 1'b1;
			end
		end
		map = span.is_dist ? dist_map : in_span;
	end

endmodule

// ----- sv/lte_rb_allocation_decoder.sv -----
// ----------------------------------------------------------------------------
// lte_rb_allocation_decoder
// decodes a downlink allocation field of a 25-block carrier into a block map
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// request   in   start, busy           mode, alloc_field
// result    out  done (one cycle)      rb_bitmap, rb_count, first_block,
//                                      valid_res
//
// one request per cycle; its result shows on done after the register stages
// three register stages: riv split by 25, span and bitmap decode, span map
// busy stays low, the pipeline never stalls since results cannot be held off
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module lte_rb_allocation_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [lrad_pkg::FIELD_W-1:0]  alloc_field,
	output logic                          done,
	output logic [lrad_pkg::NRB-1:0]      rb_bitmap,
	output logic [lrad_pkg::CNT_W-1:0]    rb_count,
	output logic [lrad_pkg::CNT_W-1:0]    first_block,
	output logic                          valid_res
);

	localparam int unsigned NRB   = lrad_pkg::NRB;
	localparam int unsigned CNT_W = lrad_pkg::CNT_W;

	// stage 1
	logic [3:0]                   quo_c;
	logic [4:0]                   rem_c;
	logic                         riv_ok_c;
	logic                         valid_s1;
	lrad_pkg::mode_t              mode_s1;
	logic [lrad_pkg::FIELD_W-1:0] field_s1;
	logic [3:0]                   quo_s1;
	logic [4:0]                   rem_s1;
	logic                         riv_ok_s1;

	// stage 2
	logic [5:0]                   sum_c;
	lrad_pkg::span_t              span_c;
	logic [NRB-1:0]               map_c;
	logic [CNT_W-1:0]             cnt_c;
	logic [NRB-1:0]               t1_base;
	logic [3:0]                   pop_c;
	logic                         valid_s2;
	lrad_pkg::mode_t              mode_s2;
	logic                         riv_ok_s2;
	lrad_pkg::span_t              span_s2;
	logic [NRB-1:0]               map_s2;
	logic [CNT_W-1:0]             cnt_s2;

	// stage 3
	logic [NRB-1:0]               span_map_c;
	logic                         valid_s3;
	logic [NRB-1:0]               map_s3;
	logic [CNT_W-1:0]             cnt_s3;
	logic [CNT_W-1:0]             first_s3;
	logic                         res_ok_s3;

	assign busy = 1'b0;

	lrad_riv_split u_split (
		.alloc_field (alloc_field),
		.quo         (quo_c),
		.rem         (rem_c),
		.riv_ok      (riv_ok_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1   <= lrad_pkg::mode_t'(mode);
		field_s1  <= alloc_field;
		quo_s1    <= quo_c;
		rem_s1    <= rem_c;
		riv_ok_s1 <= riv_ok_c;
	end

	always_comb begin
		sum_c = 6'(quo_s1) + 6'(rem_s1);
		if (sum_c <= 6'(NRB - 1)) begin
			span_c.len   = CNT_W'(quo_s1) + 5'd1;
			span_c.start = rem_s1;
		end else begin
			span_c.len   = 5'(NRB + 1) - CNT_W'(quo_s1);
			span_c.start = 5'(NRB - 1) - rem_s1;
		end
		span_c.is_dist = (mode_s1 == lrad_pkg::MODE_DIST);

		map_c   = '0;
		t1_base = '0;
		pop_c   = '0;
		cnt_c   = '0;
		case (mode_s1)
			lrad_pkg::MODE_T0: begin
				for (int i = 0; i < lrad_pkg::T0_PAIRS; i++) begin
					map_c[2*i +: 2] = {2{field_s1[i]}};
					pop_c = pop_c + 4'(field_s1[i]);
				end
				map_c[NRB-1] = field_s1[lrad_pkg::T0_PAIRS];
				cnt_c = {pop_c, 1'b0} + CNT_W'(field_s1[lrad_pkg::T0_PAIRS]);
			end
			lrad_pkg::MODE_T1: begin
				for (int i = 0; i < lrad_pkg::T1_BITS; i++) begin
					t1_base[2*i] = field_s1[i+2];
					pop_c = pop_c + 4'(field_s1[i+2]);
				end
				cnt_c = CNT_W'(pop_c);
				case (field_s1[1:0])
					2'b00:   map_c = t1_base;
					2'b01:   map_c = t1_base << 1;
					2'b10:   map_c = t1_base << 4;
					2'b11:   map_c = t1_base << 3;
					default: map_c = t1_base;
				endcase
			end
			default: begin
				map_c = '0;
				cnt_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mode_s2   <= mode_s1;
		riv_ok_s2 <= riv_ok_s1;
		span_s2   <= span_c;
		map_s2    <= map_c;
		cnt_s2    <= cnt_c;
	end

	lrad_span_map u_span (
		.span (span_s2),
		.map  (span_map_c)
	);

	always_ff @(posedge clk) begin
		if (mode_s2 inside {lrad_pkg::MODE_T0, lrad_pkg::MODE_T1}) begin
			map_s3    <= map_s2;
			cnt_s3    <= cnt_s2;
			first_s3  <= '0;
			res_ok_s3 <= 1'b1;
		end else if (riv_ok_s2) begin
			map_s3    <= span_map_c;
			cnt_s3    <= span_s2.len;
			first_s3  <= span_s2.start;
			res_ok_s3 <= 1'b1;
		end else begin
			map_s3    <= '0;
			cnt_s3    <= '0;
			first_s3  <= '0;
			res_ok_s3 <= 1'b0;
		end
	end

	assign done        = valid_s3;
	assign rb_bitmap   = map_s3;
	assign rb_count    = cnt_s3;
	assign first_block = first_s3;
	assign valid_res   = res_ok_s3;

endmodule

// ----- sv/lrad_checker.sv -----
// ----------------------------------------------------------------------------
// lrad_checker
// port-level checks of the resource allocation decoder, bound to the top
// ----------------------------------------------------------------------------
module lrad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    mode,
	input logic                          done,
	input logic [lrad_pkg::NRB-1:0]      rb_bitmap,
	input logic [lrad_pkg::CNT_W-1:0]    rb_count,
	input logic [lrad_pkg::CNT_W-1:0]    first_block,
	input logic                          valid_res
);

	// every accepted request gives exactly one result, on done after the pipeline stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted request gave no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without request");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_res) |->
			(rb_bitmap == '0 && rb_count == '0 && first_block == '0))
		else $error("invalid result not cleared");

	// bitmap modes always decode and have no start block
	a_bitmap_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(mode, 3) == lrad_pkg::MODE_T0 ||
			$past(mode, 3) == lrad_pkg::MODE_T1)) |->
			(valid_res && first_block == '0))
		else $error("bitmap mode result malformed");

	// localized span: count matches map and span stays on the carrier
	a_localized: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_res && $past(mode, 3) == lrad_pkg::MODE_LOC) |->
			($countones(rb_bitmap) == rb_count &&
			 (6'(first_block) + 6'(rb_count)) <= 6'(lrad_pkg::NRB)))
		else $error("localized span inconsistent");

endmodule

bind lte_rb_allocation_decoder lrad_checker u_lrad_checker (.*);
